// ===== hw/rtl/tlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfd_pkg
// Shared codes and widths for the type-length frame deframer.
// ----------------------------------------------------------------------------
package tlfd_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // The length high byte lands at this bit position.
    localparam int LEN_HI_SHIFT = 8;

    // Decoder phases.
    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LEN_LO  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LEN_HI  = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_WAIT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE_B     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd3;

    // One result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                size_error;
        logic                store_valid;
        logic [LEN_W-1:0]    store_offset;
        logic [BYTE_W-1:0]   store_data;
        logic [BYTE_W-1:0]   done_type;
        logic [LEN_W-1:0]    done_length;
    } t_result;

endpackage

// ===== hw/rtl/type_length_frame_deframer.sv =====
// The result word of a byte is loaded into the result register as the byte is accepted.
// Throughput: one received byte per cycle while the result register is free or being taken.
// The input is ready whenever the result register is empty or being taken.
// Reset (synchronous, active low): decoder goes idle, count and flags clear,
// registers return to type A 0, type B 1, max payload 256, capacity 256.
// ----------------------------------------------------------------------------
// type_length_frame_deframer
// Finds type-length frames in a byte stream and gives one result per byte.
// ----------------------------------------------------------------------------
module type_length_frame_deframer
    import tlfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Received byte channel.
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    // Result channel.
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_size_error,
    output logic                  o_store_valid,
    output logic [LEN_W-1:0]      o_store_offset,
    output logic [BYTE_W-1:0]     o_store_data,
    output logic [BYTE_W-1:0]     o_done_type,
    output logic [LEN_W-1:0]      o_done_length
);

    // Configuration registers.
    logic [BYTE_W-1:0] r_type_a;
    logic [BYTE_W-1:0] r_type_b;
    logic [LEN_W-1:0]  r_max_payload;
    logic [LEN_W-1:0]  r_capacity;

    // Frame state.
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_held_type, n_held_type;
    logic [LEN_W-1:0]   r_held_length, n_held_length;
    logic [LEN_W-1:0]   r_count, n_count;
    logic               r_discard, n_discard;

    // Result register.
    logic    r_res_valid;
    t_result r_res, n_res;

    logic            accept;
    logic [LEN_W-1:0] full_length;
    logic [LEN_W-1:0] count_inc;
    logic            oversize;

    // A new byte may enter whenever the result register is free this cycle.
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    assign full_length = r_held_length | (LEN_W'(i_rx_byte) << LEN_HI_SHIFT);
    assign oversize    = (full_length > r_max_payload) || (full_length > r_capacity);
    assign count_inc   = r_count + LEN_W'(1);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_a      <= '0;
            r_type_b      <= BYTE_W'(1);
            r_max_payload <= LEN_W'(256);
            r_capacity    <= LEN_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TYPE_CODE_A:     r_type_a      <= i_cfg_data[BYTE_W-1:0];
                REG_TYPE_CODE_B:     r_type_b      <= i_cfg_data[BYTE_W-1:0];
                REG_MAX_PAYLOAD:     r_max_payload <= i_cfg_data[LEN_W-1:0];
                REG_BUFFER_CAPACITY: r_capacity    <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-byte frame decoding and result word.
    always_comb begin
        n_phase       = r_phase;
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_count       = r_count;
        n_discard     = r_discard;
        n_res         = '0;
        case (r_phase)
            PHASE_IDLE: begin
                if (i_rx_byte == r_type_a || i_rx_byte == r_type_b) begin
                    n_held_type   = i_rx_byte;
                    n_held_length = '0;
                    n_count       = '0;
                    n_discard     = 1'b0;
                    n_phase       = PHASE_LEN_LO;
                end
            end
            PHASE_LEN_LO: begin
                n_held_length = LEN_W'(i_rx_byte);
                n_phase       = PHASE_LEN_HI;
            end
            PHASE_LEN_HI: begin
                n_held_length = full_length;
                n_count       = '0;
                n_discard     = oversize;
                if (full_length == '0) begin
                    // Empty frame completes on its header.
                    n_res.status  = STATUS_COMPLETE;
                    n_res.done_type = r_held_type;
                    n_phase       = PHASE_IDLE;
                    n_held_type   = '0;
                    n_held_length = '0;
                    n_discard     = 1'b0;
                end else begin
                    n_phase          = PHASE_PAYLOAD;
                    n_res.size_error = oversize;
                end
            end
            default: begin
                // Payload byte: store it if the frame is kept and it fits.
                if (!r_discard && (r_count < r_capacity)) begin
                    n_res.store_valid  = 1'b1;
                    n_res.store_offset = r_count;
                    n_res.store_data   = i_rx_byte;
                end
                n_count = count_inc;
                if (count_inc >= r_held_length) begin
                    if (r_discard) begin
                        n_res.status     = STATUS_DROPPED;
                        n_res.size_error = 1'b1;
                    end else begin
                        n_res.status      = STATUS_COMPLETE;
                        n_res.done_type   = r_held_type;
                        n_res.done_length = r_held_length;
                    end
                    n_phase       = PHASE_IDLE;
                    n_held_type   = '0;
                    n_held_length = '0;
                    n_count       = '0;
                    n_discard     = 1'b0;
                end
            end
        endcase
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PHASE_IDLE;
            r_held_type   <= '0;
            r_held_length <= '0;
            r_count       <= '0;
            r_discard     <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_count       <= n_count;
            r_discard     <= n_discard;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_status       = r_res.status;
    assign o_size_error   = r_res.size_error;
    assign o_store_valid  = r_res.store_valid;
    assign o_store_offset = r_res.store_offset;
    assign o_store_data   = r_res.store_data;
    assign o_done_type    = r_res.done_type;
    assign o_done_length  = r_res.done_length;

    // A finished or dropped frame leaves the decoder idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != STATUS_WAIT) |-> (r_phase == PHASE_IDLE))
        else $error("frame end did not return decoder to idle");

    // A dropped frame always flags a size error.
    a_drop_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == STATUS_DROPPED) |-> o_size_error)
        else $error("dropped frame without size error");

    // Stored bytes never come from a discarded frame.
    a_store_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_store_valid) |-> (!o_size_error && o_status != STATUS_DROPPED))
        else $error("byte stored from discarded frame");

    // While a result is waiting, no byte enters.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> ($stable(r_phase) && $stable(r_count)))
        else $error("frame state moved while result stalled");

endmodule

// ===== dv/tb_type_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_type_length_frame_deframer
// Self-checking bench for the type-length frame deframer. A directed opening
// covers zero-length, oversize, equal type codes and a capacity change in the
// middle of a frame. Random phases then mix whole frames, broken frames and
// noise under varied register settings and handshake idling. Each result word
// is checked field by field against a local model of the decoder.
// ----------------------------------------------------------------------------
module tb_type_length_frame_deframer;
    import tlfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES    = 8;
    localparam int HALF_PHASE  = 42;

    // DUT ports.
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_rx_valid;
    logic                  o_rx_ready;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_res_valid;
    logic                  i_res_ready;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_size_error;
    logic                  o_store_valid;
    logic [LEN_W-1:0]      o_store_offset;
    logic [BYTE_W-1:0]     o_store_data;
    logic [BYTE_W-1:0]     o_done_type;
    logic [LEN_W-1:0]      o_done_length;

    // Bytes waiting to be sent and result words waiting to be seen.
    logic [BYTE_W-1:0] pending_bytes[$];
    t_result           expected_words[$];

    // Mirror of the configuration registers.
    logic [BYTE_W-1:0] cfg_type_a;
    logic [BYTE_W-1:0] cfg_type_b;
    logic [LEN_W-1:0]  cfg_max_payload;
    logic [LEN_W-1:0]  cfg_capacity;

    // Mirror of the frame decoder state.
    logic [PHASE_W-1:0] dec_phase;
    logic [BYTE_W-1:0]  dec_type;
    logic [LEN_W-1:0]   dec_length;
    logic [LEN_W-1:0]   dec_count;
    logic               dec_discard;

    // Handshake shaping and bookkeeping.
    int unsigned send_idle_pct;
    int unsigned res_stall_pct;
    logic        rx_taken;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned word_count;
    int unsigned n_complete;
    int unsigned n_dropped;
    int unsigned n_stored;
    int unsigned n_size_err;

    type_length_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_status       (o_status),
        .o_size_error   (o_size_error),
        .o_store_valid  (o_store_valid),
        .o_store_offset (o_store_offset),
        .o_store_data   (o_store_data),
        .o_done_type    (o_done_type),
        .o_done_length  (o_done_length)
    );

    // Clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] word %0d: %s", $realtime, word_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Return the decoder to idle with an empty frame.
    function automatic void clear_frame();
        dec_phase   = PHASE_IDLE;
        dec_type    = '0;
        dec_length  = '0;
        dec_count   = '0;
        dec_discard = 1'b0;
    endfunction

    // Advance the decoder model by one received byte and give its result word.
    function automatic t_result decode_byte(input logic [BYTE_W-1:0] rx);
        t_result w;
        w = '0;
        case (dec_phase)
            PHASE_IDLE: begin
                // Bytes are skipped until one matches a type code.
                if (rx == cfg_type_a || rx == cfg_type_b) begin
                    clear_frame();
                    dec_type  = rx;
                    dec_phase = PHASE_LEN_LO;
                end
            end
            PHASE_LEN_LO: begin
                dec_length = LEN_W'(rx);
                dec_phase  = PHASE_LEN_HI;
            end
            PHASE_LEN_HI: begin
                // The limits are sampled here, once per frame.
                dec_length  = dec_length | (LEN_W'(rx) << LEN_HI_SHIFT);
                dec_count   = '0;
                dec_discard = (dec_length > cfg_max_payload) || (dec_length > cfg_capacity);
                if (dec_length == '0) begin
                    w.status    = STATUS_COMPLETE;
                    w.done_type = dec_type;
                    clear_frame();
                end else begin
                    dec_phase    = PHASE_PAYLOAD;
                    w.size_error = dec_discard;
                end
            end
            default: begin
                // The current capacity still gates storing within a frame.
                if (!dec_discard && dec_count < cfg_capacity) begin
                    w.store_valid  = 1'b1;
                    w.store_offset = dec_count;
                    w.store_data   = rx;
                end
                dec_count = dec_count + LEN_W'(1);
                if (dec_count >= dec_length) begin
                    if (dec_discard) begin
                        w.status     = STATUS_DROPPED;
                        w.size_error = 1'b1;
                    end else begin
                        w.status      = STATUS_COMPLETE;
                        w.done_type   = dec_type;
                        w.done_length = dec_length;
                    end
                    clear_frame();
                end
            end
        endcase
        return w;
    endfunction

    // Write one register and mirror it in the model.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TYPE_CODE_A:     cfg_type_a      = val[BYTE_W-1:0];
            REG_TYPE_CODE_B:     cfg_type_b      = val[BYTE_W-1:0];
            REG_MAX_PAYLOAD:     cfg_max_payload = val;
            REG_BUFFER_CAPACITY: cfg_capacity    = val;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [BYTE_W-1:0] ta, input logic [BYTE_W-1:0] tb,
                                  input logic [LEN_W-1:0] maxp, input logic [LEN_W-1:0] cap);
        write_reg(REG_TYPE_CODE_A, CFG_DATA_W'(ta));
        write_reg(REG_TYPE_CODE_B, CFG_DATA_W'(tb));
        write_reg(REG_MAX_PAYLOAD, maxp);
        write_reg(REG_BUFFER_CAPACITY, cap);
    endtask

    // Wait until every queued byte is sent and every result word has come back.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_rx_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] ftype, input logic [LEN_W-1:0] len);
        pending_bytes.push_back(ftype);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(len[15:8]);
    endtask

    // Mostly well-formed frames with random payload; some cut short, some noise.
    task automatic queue_random_bytes(input int n_bytes);
        int                queued;
        int                len;
        int                body;
        logic [BYTE_W-1:0] ftype;
        queued = 0;
        while (queued < n_bytes) begin
            if ($urandom_range(99) < 80) begin
                ftype = $urandom_range(1) ? cfg_type_a : cfg_type_b;
                case ($urandom_range(19))
                    0, 1:    len = 0;
                    19:      len = $urandom_range(40, 25);
                    default: len = $urandom_range(24, 1);
                endcase
                body = len;
                if ($urandom_range(99) < 8) body = $urandom_range(len);
                send_header(ftype, LEN_W'(len));
                repeat (body) pending_bytes.push_back(BYTE_W'($urandom_range(255)));
                queued += 3 + body;
            end else begin
                pending_bytes.push_back(BYTE_W'($urandom_range(255)));
                queued++;
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 82; res_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  res_stall_pct = 82; end
            3:       begin send_idle_pct = 25; res_stall_pct = 25; end
            default: begin send_idle_pct = 0;  res_stall_pct = 0;  end
        endcase
    endtask

    // Driver: presents the next byte at the falling edge and shapes the result ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid  <= 1'b0;
            i_res_ready <= 1'b0;
        end else begin
            if (!i_rx_valid || rx_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= pending_bytes.pop_front();
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
            i_res_ready <= ($urandom_range(99) >= res_stall_pct);
        end
    end

    // Monitor: checks each result word and predicts each accepted byte.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        rx_taken = 1'b0;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                got = '{o_status, o_size_error, o_store_valid, o_store_offset,
                        o_store_data, o_done_type, o_done_length};
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with none outstanding");
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", got.status, want.status);
                    check_field("size_error", got.size_error, want.size_error);
                    check_field("store_valid", got.store_valid, want.store_valid);
                    check_field("store_offset", got.store_offset, want.store_offset);
                    check_field("store_data", got.store_data, want.store_data);
                    check_field("done_type", got.done_type, want.done_type);
                    check_field("done_length", got.done_length, want.done_length);
                    if (want.status == STATUS_COMPLETE) n_complete++;
                    if (want.status == STATUS_DROPPED) n_dropped++;
                    if (want.store_valid) n_stored++;
                    if (want.size_error) n_size_err++;
                end
                word_count++;
            end
            if (i_rx_valid && o_rx_ready) begin
                rx_taken = 1'b1;
                expected_words.push_back(decode_byte(i_rx_byte));
            end
            if ((o_res_valid && i_res_ready) || rx_taken || i_cfg_we) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog on cycles with no transfer at all.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Stalled for %0d cycles with %0d words outstanding.",
                 STALL_LIMIT, expected_words.size());
        $display("type_length_frame_deframer: mismatch");
        $finish;
    end

    // Stimulus.
    initial begin
        int                p;
        int                half;
        logic [BYTE_W-1:0] ta;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_res_ready = 1'b0;
        rx_taken    = 1'b0;
        mismatches  = 0;
        word_count  = 0;
        n_complete  = 0;
        n_dropped   = 0;
        n_stored    = 0;
        n_size_err  = 0;
        cfg_type_a      = 8'd0;
        cfg_type_b      = 8'd1;
        cfg_max_payload = 16'd256;
        cfg_capacity    = 16'd256;
        clear_frame();
        set_idling(0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset codes: a zero-length frame, a noise byte, then a short frame.
        send_header(8'h00, 16'h0000);
        pending_bytes.push_back(8'hAA);
        send_header(8'h01, 16'h0002);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        wait_drained();

        // A tiny payload limit: an oversize frame is dropped, a small one fits.
        write_all_regs(8'hFF, 8'h80, 16'd2, 16'd256);
        send_header(8'hFF, 16'h0003);
        repeat (3) pending_bytes.push_back(BYTE_W'($urandom_range(255)));
        send_header(8'h80, 16'h0001);
        pending_bytes.push_back(8'h55);
        wait_drained();

        // Equal type codes and full-scale limits; stop partway into a frame.
        write_all_regs(8'h5A, 8'h5A, 16'hFFFF, 16'hFFFF);
        pending_bytes.push_back(8'h5B);
        send_header(8'h5A, 16'h0006);
        pending_bytes.push_back(8'h11);
        pending_bytes.push_back(8'h22);
        wait_drained();

        // Shrinking the buffer mid-frame stops storing but the frame completes.
        write_reg(REG_BUFFER_CAPACITY, 16'd3);
        pending_bytes.push_back(8'h33);
        pending_bytes.push_back(8'h44);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'h66);
        wait_drained();

        // Random phases under varied settings and idling.
        for (p = 0; p < N_PHASES; p++) begin
            ta = BYTE_W'($urandom_range(255));
            case (p)
                4: write_all_regs(ta, BYTE_W'($urandom_range(255)), 16'hFFFF, 16'hFFFF);
                5: write_all_regs(ta, BYTE_W'($urandom_range(255)), 16'd0,
                                  LEN_W'($urandom_range(30)));
                6: write_all_regs(ta, ta, 16'hFFFF, 16'd0);
                default: write_all_regs(ta, ($urandom_range(3) == 0) ? ta
                                            : BYTE_W'($urandom_range(255)),
                                        LEN_W'($urandom_range(30)),
                                        LEN_W'($urandom_range(30)));
            endcase
            set_idling(p % 4);
            // The sender holds off at mid-phase until every result is back.
            for (half = 0; half < 2; half++) begin
                queue_random_bytes(HALF_PHASE);
                wait_drained();
            end
        end

        // Largest length: an oversize header, left running at the end.
        write_reg(REG_MAX_PAYLOAD, 16'd16);
        set_idling(0);
        send_header(cfg_type_a, 16'hFFFF);
        repeat (4) pending_bytes.push_back(BYTE_W'($urandom_range(255)));
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (expected_words.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_words.size()));
        end
        $display("Checked %0d result words over %0d register settings.",
                 word_count, N_PHASES + 5);
        $display("Frames complete %0d, dropped %0d; bytes stored %0d; size errors %0d.",
                 n_complete, n_dropped, n_stored, n_size_err);
        if (mismatches == 0) begin
            $display("type_length_frame_deframer: match");
        end else begin
            $display("type_length_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule

// ===== type_length_frame_deframer.f =====
hw/rtl/tlfd_pkg.sv
hw/rtl/type_length_frame_deframer.sv
dv/tb_type_length_frame_deframer.sv
